### rtl/core/ordered_packet_filter_rule_table_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the rule table core
// shared concurrent assertion forms, clocked on clk with async reset
// ----------------------------------------------------------------------------
`ifndef ORDERED_PACKET_FILTER_RULE_TABLE_CORE_MACROS_SVH
`define ORDERED_PACKET_FILTER_RULE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define OPRT_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define OPRT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/oprt_pkg.sv
// ----------------------------------------------------------------------------
// oprt_pkg
// types and constants shared by the rule table front, back and top level
// ----------------------------------------------------------------------------
package oprt_pkg;

	localparam int MAX_RULES = 64;
	localparam int IDX_W     = $clog2(MAX_RULES);
	localparam int CNT_W     = IDX_W + 1;

	typedef enum logic [2:0] {
		OP_FILTER = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_MODIFY = 3'd3,
		OP_SWAP   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_POS  = 2'd1,
		ST_FULL     = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		CFG_IDX_CONTINUE = 2'd0,
		CFG_IDX_NO_MATCH = 2'd1
	} cfg_idx_e_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] mask;
		logic [15:0] port_low;
		logic [15:0] port_high;
		logic [15:0] action;
		logic [7:0]  protocol;
		logic        direction;
		logic        address_only;
	} entry_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [6:0]  position;
		entry_t      rule;
		logic [15:0] local_port;
		logic [15:0] remote_port;
	} cmd_t;

	// queue head seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_SCAN_RD,
		BS_SCAN_EV,
		BS_MOVE_CHK,
		BS_MOVE_WR,
		BS_WRITE,
		BS_SWAP_RD0,
		BS_SWAP_RD1,
		BS_SWAP_WR0,
		BS_SWAP_WR1,
		BS_FIN
	} bstate_t;

endpackage

### rtl/core/oprt_front.sv
// ----------------------------------------------------------------------------
// oprt_front
// accepts command words and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module oprt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  oprt_pkg::cmd_t in_cmd,
	output oprt_pkg::qhead_t head,
	input  logic          pop
);
	import oprt_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	// stall only when both slots are taken
	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/oprt_back.sv
// ----------------------------------------------------------------------------
// oprt_back
// executes queued commands on the rule memory and holds the result word
// ----------------------------------------------------------------------------
module oprt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  oprt_pkg::qhead_t   head,
	output logic               pop,
	input  logic [15:0]        continue_mask,
	input  logic [15:0]        no_match_action,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [15:0]        verdict,
	output logic [6:0]         rules_held
);
	import oprt_pkg::*;

	`include "ordered_packet_filter_rule_table_core_macros.svh"

	bstate_t          state_q;
	bstate_t          state_d;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] total_q;
	logic [15:0]      act_q;
	logic [1:0]       stat_q;
	entry_t           tmp_q;

	entry_t           mem [MAX_RULES];
	entry_t           rd_data_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [15:0]      verdict_q;

	// position checks on the queue head
	logic signed [8:0] pos9;
	logic signed [8:0] tot9;
	logic              bad_ins;
	logic              bad_pos;
	logic              bad_swap;
	logic              full;
	op_e_t             head_op;
	op_e_t             cur_op;

	assign pos9     = $signed({{2{head.cmd.position[6]}}, head.cmd.position});
	assign tot9     = $signed({2'b00, total_q});
	assign bad_ins  = (pos9 < -9'sd1) || (pos9 > tot9 - 9'sd1);
	assign bad_pos  = (pos9 < 9'sd0) || (pos9 > tot9 - 9'sd1);
	assign bad_swap = (pos9 < 9'sd0) || (pos9 > tot9 - 9'sd2);
	assign full     = (total_q >= CNT_W'(MAX_RULES));
	assign head_op  = op_e_t'(head.cmd.opcode);
	assign cur_op   = op_e_t'(cmd_q.opcode);

	// loop bounds
	logic [IDX_W-1:0] ins_at;
	logic             idx_last;
	logic             out_free;

	assign ins_at   = IDX_W'(cmd_q.position + 7'd1);
	assign idx_last = ({1'b0, idx_q} + CNT_W'(1)) == total_q;
	assign out_free = !out_valid_q || !out_stall;

	// rule match on the word read from memory
	logic [15:0] pkt_port;
	logic        hit;
	logic        stop;

	assign pkt_port = cmd_q.rule.direction ? cmd_q.remote_port : cmd_q.local_port;
	assign hit = (rd_data_q.direction == cmd_q.rule.direction)
		&& ((rd_data_q.address & rd_data_q.mask) == (cmd_q.rule.address & rd_data_q.mask))
		&& (rd_data_q.address_only
			|| ((rd_data_q.protocol == cmd_q.rule.protocol)
				&& (pkt_port >= rd_data_q.port_low)
				&& (pkt_port <= rd_data_q.port_high)));
	assign stop = hit && ((rd_data_q.action & continue_mask) == 16'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (head.valid) begin
					case (head_op)
						OP_FILTER: state_d = (total_q == '0) ? BS_FIN : BS_SCAN_RD;
						OP_INSERT: state_d = (bad_ins || full) ? BS_FIN : BS_MOVE_CHK;
						OP_DELETE: state_d = bad_pos ? BS_FIN : BS_MOVE_CHK;
						OP_MODIFY: state_d = bad_pos ? BS_FIN : BS_WRITE;
						OP_SWAP:   state_d = bad_swap ? BS_FIN : BS_SWAP_RD0;
						default:   state_d = BS_FIN;
					endcase
				end
			end
			BS_SCAN_RD:  state_d = BS_SCAN_EV;
			BS_SCAN_EV:  state_d = (stop || idx_last) ? BS_FIN : BS_SCAN_RD;
			BS_MOVE_CHK: begin
				if (cur_op == OP_INSERT) begin
					state_d = (idx_q == ins_at) ? BS_WRITE : BS_MOVE_WR;
				end else begin
					state_d = idx_last ? BS_FIN : BS_MOVE_WR;
				end
			end
			BS_MOVE_WR:  state_d = BS_MOVE_CHK;
			BS_WRITE:    state_d = BS_FIN;
			BS_SWAP_RD0: state_d = BS_SWAP_RD1;
			BS_SWAP_RD1: state_d = BS_SWAP_WR0;
			BS_SWAP_WR0: state_d = BS_SWAP_WR1;
			BS_SWAP_WR1: state_d = BS_FIN;
			BS_FIN:      state_d = out_free ? BS_IDLE : BS_FIN;
			default:     state_d = BS_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		case (state_q)
			BS_IDLE:    pop = head.valid;
			BS_SCAN_RD: rd_en = 1'b1;
			BS_MOVE_CHK: begin
				if (cur_op == OP_INSERT) begin
					rd_en   = (idx_q != ins_at);
					rd_addr = idx_q - IDX_W'(1);
				end else begin
					rd_en   = !idx_last;
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			BS_MOVE_WR:  wr_en = 1'b1;
			BS_WRITE: begin
				wr_en   = 1'b1;
				wr_data = cmd_q.rule;
			end
			BS_SWAP_RD0: rd_en = 1'b1;
			BS_SWAP_RD1: begin
				rd_en   = 1'b1;
				rd_addr = idx_q + IDX_W'(1);
			end
			BS_SWAP_WR0: wr_en = 1'b1;
			BS_SWAP_WR1: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + IDX_W'(1);
				wr_data = tmp_q;
			end
			default: begin
			end
		endcase
	end

	// rule memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// command and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			BS_IDLE: begin
				cmd_q <= head.cmd;
				act_q <= (head_op == OP_FILTER) ? no_match_action : 16'd0;
				case (head_op)
					OP_INSERT: begin
						idx_q  <= total_q[IDX_W-1:0];
						stat_q <= bad_ins ? ST_BAD_POS : (full ? ST_FULL : ST_OK);
					end
					OP_DELETE, OP_MODIFY: begin
						idx_q  <= head.cmd.position[IDX_W-1:0];
						stat_q <= bad_pos ? ST_BAD_POS : ST_OK;
					end
					OP_SWAP: begin
						idx_q  <= head.cmd.position[IDX_W-1:0];
						stat_q <= bad_swap ? ST_BAD_POS : ST_OK;
					end
					default: begin
						idx_q  <= '0;
						stat_q <= ST_OK;
					end
				endcase
			end
			BS_SCAN_EV: begin
				if (hit) begin
					act_q <= rd_data_q.action;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			BS_MOVE_WR: begin
				idx_q <= (cur_op == OP_INSERT) ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
			end
			BS_SWAP_RD1: tmp_q <= rd_data_q;
			default: begin
			end
		endcase
	end

	// rule count and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BS_IDLE && head.valid && head_op == OP_CLEAR) begin
				total_q <= '0;
			end
			if (state_q == BS_WRITE && cur_op == OP_INSERT) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (state_q == BS_MOVE_CHK && cur_op == OP_DELETE && idx_last) begin
				total_q <= total_q - CNT_W'(1);
			end
			if (state_q == BS_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (state_q == BS_FIN && out_free) begin
			status_q  <= stat_q;
			verdict_q <= act_q;
		end
	end

	logic [CNT_W-1:0] held_q;

	always_ff @(posedge clk) begin
		if (state_q == BS_FIN && out_free) begin
			held_q <= total_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign verdict    = verdict_q;
	assign rules_held = 7'(held_q);

	`OPRT_ASSERT_IMPLY(a_total_bound, 1'b1, total_q <= CNT_W'(MAX_RULES))
	`OPRT_ASSERT_IMPLY(a_scan_in_range, state_q == BS_SCAN_RD, {1'b0, idx_q} < total_q)
	`OPRT_ASSERT_IMPLY(a_move_nonempty, state_q == BS_MOVE_WR, total_q != '0)
	`OPRT_ASSERT_NEXT(a_pop_leaves_idle, state_q == BS_IDLE && head.valid, state_q != BS_IDLE)

endmodule

### rtl/core/ordered_packet_filter_rule_table_core.sv
// ----------------------------------------------------------------------------
// ordered_packet_filter_rule_table_core
// ordered firewall rule table: insert, delete, modify, swap, clear, filter
// ----------------------------------------------------------------------------
//  channel  | handshake            | contents
//  ---------+----------------------+---------------------------------------
//  command  | in_valid / in_stall  | opcode, position, rule and packet fields
//  result   | out_valid / out_stall| status, verdict, rules_held
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  filter reads and then compares each rule in order, stopping at the last rule
//  or at a hit whose action has no continue_mask bit; insert and delete shift
//  rules one at a time through the rule memory; modify writes one rule, swap two
//  a two-word queue takes commands while the back end works or the result waits
//  reset empties the table; rule memory contents are not cleared
//  cfg_ready is always high; writes to unused indexes are ignored
// ----------------------------------------------------------------------------
module ordered_packet_filter_rule_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [6:0]  position,
	input  logic [31:0] address,
	input  logic [31:0] mask,
	input  logic        direction,
	input  logic [7:0]  protocol,
	input  logic        address_only,
	input  logic [15:0] port_low,
	input  logic [15:0] port_high,
	input  logic [15:0] rule_action,
	input  logic [15:0] local_port,
	input  logic [15:0] remote_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] verdict,
	output logic [6:0]  rules_held,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import oprt_pkg::*;

	cmd_t        in_cmd;
	qhead_t      head;
	logic        pop;
	logic [15:0] continue_mask_q;
	logic [15:0] no_match_action_q;

	// pack the command word
	always_comb begin
		in_cmd.opcode            = opcode;
		in_cmd.position          = position;
		in_cmd.rule.address      = address;
		in_cmd.rule.mask         = mask;
		in_cmd.rule.port_low     = port_low;
		in_cmd.rule.port_high    = port_high;
		in_cmd.rule.action       = rule_action;
		in_cmd.rule.protocol     = protocol;
		in_cmd.rule.direction    = direction;
		in_cmd.rule.address_only = address_only;
		in_cmd.local_port        = local_port;
		in_cmd.remote_port       = remote_port;
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			continue_mask_q   <= 16'd1;
			no_match_action_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_e_t'(cfg_index))
				CFG_IDX_CONTINUE: continue_mask_q   <= cfg_data;
				CFG_IDX_NO_MATCH: no_match_action_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	oprt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_cmd   (in_cmd),
		.head     (head),
		.pop      (pop)
	);

	oprt_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.continue_mask   (continue_mask_q),
		.no_match_action (no_match_action_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.verdict         (verdict),
		.rules_held      (rules_held)
	);

endmodule
